FILE: design/aerl_pkg.sv
// ----------------------------------------------------------------------------
// aerl_pkg
// Shared types and constants for the audit event ring log: ring depth,
// request and response payloads, the stored entry layout and the control
// bundles passed between the pointer logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package aerl_pkg;

  // Ring geometry
  localparam int AUDIT_DEPTH = 64;
  localparam int SLOT_W      = $clog2(AUDIT_DEPTH);
  localparam int FILL_W      = $clog2(AUDIT_DEPTH + 1);
  localparam int SUM_W       = FILL_W + 1;

  // Operation codes
  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  // Action code that marks a dropped event
  localparam logic [1:0] ACT_INVALID = 2'd3;

  typedef struct packed {
    op_t                opcode;
    logic [31:0]        thread_id;
    logic [31:0]        call_number;
    logic [1:0]         action;
    logic signed [63:0] call_result;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [63:0]        event_sequence;
    logic [31:0]        event_thread;
    logic [31:0]        event_syscall;
    logic [1:0]         event_action;
    logic signed [63:0] event_result;
    logic [63:0]        total_recorded;
  } rsp_t;

  // One stored ring entry
  typedef struct packed {
    logic [63:0]        seq_stamp;
    logic [31:0]        thread;
    logic [31:0]        syscall;
    logic [1:0]         action;
    logic signed [63:0] result;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Ring port access for the current cycle
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [SLOT_W-1:0] addr;
    logic [63:0]       stamp;
  } ring_acc_t;

  // Registered response control, valid in the cycle after a transfer
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic        from_ram;
    logic [63:0] total;
  } rsp_ctl_t;

endpackage

`default_nettype wire

FILE: design/audit_event_ring_log_unit.sv
// ----------------------------------------------------------------------------
// audit_event_ring_log_unit
// Overwriting circular audit log holding the newest AUDIT_DEPTH events in
// one single-port RAM, with a newest-event read.
//
//   channel   | handshake         | payload
//   ----------+-------------------+---------------------
//   request   | start / busy      | request  (req_t)
//   response  | done (one cycle)  | response (rsp_t)
//
// One request per cycle; busy never rises. Each response is on the ports
// for one cycle, in the cycle after its transfer, when the RAM read is registered.
// Requests may follow back to back; a read right after a record sees it.
// Reset clears the pointers and the count; ring contents are not cleared.
// The receiver cannot stall, so nothing is held back on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module audit_event_ring_log_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire aerl_pkg::req_t request,
  output logic                done,
  output aerl_pkg::rsp_t      response
);

  aerl_pkg::ring_acc_t acc;
  aerl_pkg::rsp_ctl_t  info;
  aerl_pkg::entry_t    wr_entry;
  aerl_pkg::entry_t    rd_entry;
  aerl_pkg::entry_t    echo;
  aerl_pkg::entry_t    sel;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  aerl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (request.opcode),
    .action (request.action),
    .acc    (acc),
    .info   (info)
  );

  // Entry built from the request
  always_comb begin
    wr_entry.seq_stamp = acc.stamp;
    wr_entry.thread    = request.thread_id;
    wr_entry.syscall   = request.call_number;
    wr_entry.action    = request.action;
    wr_entry.result    = request.call_result;
  end

  aerl_ram #(
    .WIDTH (aerl_pkg::ENTRY_W),
    .DEPTH (aerl_pkg::AUDIT_DEPTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (acc.wr_en),
    .rd_en (acc.rd_en),
    .addr  (acc.addr),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  // Echo of the stored event for a record response
  always_ff @(posedge clk) begin
    if (acc.wr_en) begin
      echo <= wr_entry;
    end
  end

  // Response assembly
  always_comb begin
    if (info.status != aerl_pkg::ST_OK) begin
      sel = '0;
    end else if (info.from_ram) begin
      sel = rd_entry;
    end else begin
      sel = echo;
    end
    done                    = info.valid;
    response.status         = info.status;
    response.event_sequence = sel.seq_stamp;
    response.event_thread   = sel.thread;
    response.event_syscall  = sel.syscall;
    response.event_action   = sel.action;
    response.event_result   = sel.result;
    response.total_recorded = info.total;
  end

`ifndef SYNTH
  // A response only follows a transfer outside reset
  a_done_follows_start: assert property (@(posedge clk)
    done |-> $past(start && !rst))
    else $error("response without a preceding transfer");

  // A rejected record leaves the count alone
  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && response.status == aerl_pkg::ST_REJECT |->
      response.total_recorded == $past(info.total))
    else $error("rejected record changed the count");

  // A stored record bumps the count by one and stamps it
  a_record_bumps_count: assert property (@(posedge clk) disable iff (rst)
    done && !info.from_ram && response.status == aerl_pkg::ST_OK |->
      response.total_recorded == $past(info.total) + 64'd1 &&
      response.event_sequence == response.total_recorded)
    else $error("record count or stamp mismatch");
`endif

endmodule

`default_nettype wire

FILE: design/aerl_ram.sv
// ----------------------------------------------------------------------------
// aerl_ram
// Single-port synchronous RAM with registered read data.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module aerl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/aerl_ctrl.sv
// ----------------------------------------------------------------------------
// aerl_ctrl
// Ring pointer logic: oldest slot, fill count and the running record count.
// Picks the ring slot for each transfer and registers the response control.
// ----------------------------------------------------------------------------
`default_nettype none

module aerl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire aerl_pkg::op_t      opcode,
  input  wire logic [1:0]         action,
  output aerl_pkg::ring_acc_t     acc,
  output aerl_pkg::rsp_ctl_t      info
);

  logic [aerl_pkg::SLOT_W-1:0] oldest;
  logic [aerl_pkg::FILL_W-1:0] fill;
  logic [63:0]                 total;

  logic                        is_rec;
  logic                        rec_ok;
  logic                        full;
  logic                        empty;
  logic [aerl_pkg::SLOT_W-1:0] wr_slot;
  logic [aerl_pkg::SLOT_W-1:0] newest_slot;
  logic [aerl_pkg::SLOT_W-1:0] oldest_inc;

  // Slot plus offset, wrapped once: both operands stay below twice the depth
  function automatic logic [aerl_pkg::SLOT_W-1:0] slot_add(
    input logic [aerl_pkg::SLOT_W-1:0] base,
    input logic [aerl_pkg::FILL_W-1:0] off
  );
    logic [aerl_pkg::SUM_W-1:0] sum;
    sum = aerl_pkg::SUM_W'(base) + aerl_pkg::SUM_W'(off);
    if (sum >= aerl_pkg::SUM_W'(aerl_pkg::AUDIT_DEPTH)) begin
      sum = sum - aerl_pkg::SUM_W'(aerl_pkg::AUDIT_DEPTH);
    end
    return sum[aerl_pkg::SLOT_W-1:0];
  endfunction

  // Slot selection
  always_comb begin
    is_rec      = (opcode == aerl_pkg::OP_RECORD);
    rec_ok      = is_rec && (action != aerl_pkg::ACT_INVALID);
    full        = (fill == aerl_pkg::FILL_W'(aerl_pkg::AUDIT_DEPTH));
    empty       = (fill == '0);
    wr_slot     = full ? oldest : slot_add(oldest, fill);
    newest_slot = slot_add(oldest, fill - aerl_pkg::FILL_W'(1));
    oldest_inc  = slot_add(oldest, aerl_pkg::FILL_W'(1));

    acc.wr_en = accept && rec_ok;
    acc.rd_en = accept && !is_rec && !empty;
    acc.addr  = is_rec ? wr_slot : newest_slot;
    acc.stamp = total + 64'd1;
  end

  // Pointer update and response control
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest        <= '0;
      fill          <= '0;
      total         <= '0;
      info.valid    <= 1'b0;
      info.status   <= aerl_pkg::ST_OK;
      info.from_ram <= 1'b0;
      info.total    <= '0;
    end else begin
      info.valid <= accept;
      if (accept) begin
        info.from_ram <= !is_rec && !empty;
        if (is_rec) begin
          info.status <= rec_ok ? aerl_pkg::ST_OK : aerl_pkg::ST_REJECT;
        end else begin
          info.status <= empty ? aerl_pkg::ST_EMPTY : aerl_pkg::ST_OK;
        end
        if (rec_ok) begin
          total      <= acc.stamp;
          info.total <= acc.stamp;
          if (full) begin
            oldest <= oldest_inc;
          end else begin
            fill <= fill + aerl_pkg::FILL_W'(1);
          end
        end else begin
          info.total <= total;
        end
      end
    end
  end

endmodule

`default_nettype wire
